@@ hw/rtl/cwlcg_pkg.sv @@
// Shared types, constants and helpers for the combined LCG range generator.
// No dependencies; used by cwlcg_div, cwlcg_gen and combined_lcg_range_random.
package cwlcg_pkg;

  // generator multipliers
  localparam logic [7:0] MULT_A = 8'd171;
  localparam logic [7:0] MULT_B = 8'd172;
  localparam logic [7:0] MULT_C = 8'd170;

  // register reset values
  localparam logic [15:0] MODULUS_A_RST = 16'd30269;
  localparam logic [15:0] MODULUS_B_RST = 16'd30307;
  localparam logic [15:0] MODULUS_C_RST = 16'd30323;
  localparam logic [15:0] SEED_RST      = 16'd1;

  // attempts in all before the last value is taken as is
  localparam int RETRY_LIMIT = 64;
  localparam int TRY_W       = $clog2(RETRY_LIMIT);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_C   = 3'd5;

  typedef enum logic [1:0] {
    GEN_A,
    GEN_B,
    GEN_C
  } gen_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_LIMW,
    S_GEN,
    S_GENW,
    S_BYTE,
    S_CHECK,
    S_MOD,
    S_MODW,
    S_OUT
  } seq_state_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

  // generator state update from the sequencer
  typedef struct packed {
    logic        wr;
    gen_sel_t    sel;
    logic [15:0] value;
  } gen_upd_t;

  // generator state and moduli seen by the sequencer
  typedef struct packed {
    logic [15:0] gen_a;
    logic [15:0] gen_b;
    logic [15:0] gen_c;
    logic [15:0] modulus_a;
    logic [15:0] modulus_b;
    logic [15:0] modulus_c;
  } gen_view_t;

  function automatic logic [7:0] gen_mult(input gen_sel_t sel);
    case (sel)
      GEN_A:   return MULT_A;
      GEN_B:   return MULT_B;
      GEN_C:   return MULT_C;
      default: return MULT_A;
    endcase
  endfunction

  // number of bytes minus one for a given span
  function automatic logic [1:0] byte_count_m1(input logic [31:0] span);
    if (span <= 32'h0000_0100) begin
      return 2'd0;
    end else if (span <= 32'h0001_0000) begin
      return 2'd1;
    end else if (span <= 32'h0100_0000) begin
      return 2'd2;
    end else begin
      return 2'd3;
    end
  endfunction

  // top of the raw value range for a byte count
  function automatic logic [31:0] span_ceiling(input logic [1:0] nb_m1);
    case (nb_m1)
      2'd0:    return 32'h0000_0100;
      2'd1:    return 32'h0001_0000;
      2'd2:    return 32'h0100_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

@@ hw/rtl/cwlcg_div.sv @@
// Shared restoring divider, one quotient bit per cycle, remainder only.
// Depends on cwlcg_pkg for the request and response structs.
module cwlcg_div (
  input  logic                clk,
  input  logic                rst,
  input  cwlcg_pkg::div_req_t req,
  output cwlcg_pkg::div_rsp_t rsp
);
  import cwlcg_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic        fits;

  // one shift and trial subtract per step
  always_comb begin
    trial = {rem, dvd[31]};
    fits  = trial >= {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      dvd <= {dvd[30:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

@@ hw/rtl/cwlcg_gen.sv @@
// Generator seeds and moduli with the configuration write port.
// Depends on cwlcg_pkg for register indexes and the update and view structs.
module cwlcg_gen (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cwlcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data,
  input  cwlcg_pkg::gen_upd_t              upd,
  output cwlcg_pkg::gen_view_t             view
);
  import cwlcg_pkg::*;

  logic [15:0] gen_a, gen_b, gen_c;
  logic [15:0] modulus_a, modulus_b, modulus_c;
  logic [15:0] seed_load;

  // a zero seed loads as one
  assign seed_load = (cfg_data == 16'd0) ? 16'd1 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_a     <= SEED_RST;
      gen_b     <= SEED_RST;
      gen_c     <= SEED_RST;
      modulus_a <= MODULUS_A_RST;
      modulus_b <= MODULUS_B_RST;
      modulus_c <= MODULUS_C_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS_A: modulus_a <= cfg_data;
        CFG_MODULUS_B: modulus_b <= cfg_data;
        CFG_MODULUS_C: modulus_c <= cfg_data;
        CFG_START_A:   gen_a     <= seed_load;
        CFG_START_B:   gen_b     <= seed_load;
        CFG_START_C:   gen_c     <= seed_load;
        default:       ;
      endcase
    end else if (upd.wr) begin
      case (upd.sel)
        GEN_A:   gen_a <= upd.value;
        GEN_B:   gen_b <= upd.value;
        GEN_C:   gen_c <= upd.value;
        default: ;
      endcase
    end
  end

  assign view.gen_a     = gen_a;
  assign view.gen_b     = gen_b;
  assign view.gen_c     = gen_c;
  assign view.modulus_a = modulus_a;
  assign view.modulus_b = modulus_b;
  assign view.modulus_c = modulus_c;

endmodule

@@ hw/rtl/combined_lcg_range_random.sv @@
// Range-limited random draw from three combined congruential generators.
// Depends on cwlcg_pkg, cwlcg_div and cwlcg_gen.
//
// Usage: a beat on s_tdata carries span; the block answers with one beat on
// m_tdata carrying draw, uniform in 0 .. span-1 (0 when span is 0).
// s_tready is high only while the sequencer is idle; one request is worked
// on at a time. Configuration (moduli 0..2, seeds 3..5) must be written through
// cfg_we / cfg_index / cfg_data only while no request is in flight; the block
// does not enforce this. A seed write reloads that generator at once.
// Every modulo goes through one shared 32-step divider. A zero span skips
// it and answers zero. Otherwise the sequencer reduces the limit, then for
// each of the 1 to 4 bytes steps the three generators and combines their
// low bytes, checks the value against the limit and, once it is taken,
// reduces it modulo span; each rejected attempt starts the bytes again, at
// most 64 attempts. A generator with modulus 0 skips the divider.
// Reset (synchronous, rst high) clears the sequencer and output beat,
// and restores the default moduli and seeds of one.
// When the receiver stalls, the result beat is held in the output register
// and the next request is taken; its result waits until the beat is taken.
module combined_lcg_range_random (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [cwlcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,  // [31:0] span
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata   // [31:0] draw
);
  import cwlcg_pkg::*;

  seq_state_t state, state_next;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  gen_upd_t  gen_upd;
  gen_view_t view;

  logic [31:0]      span;
  logic [1:0]       nb_m1;
  logic [1:0]       idx;
  logic [TRY_W-1:0] tries;
  gen_sel_t         sel;
  gen_sel_t         sel_next;
  logic [31:0]      limit;
  logic [31:0]      value;
  logic [31:0]      res;

  logic [15:0] seed_cur;
  logic [15:0] mod_cur;
  logic [23:0] prod;
  logic [7:0]  rnd_byte;
  logic        last_sel;
  logic        take;
  logic        out_free;

  // shared divider
  cwlcg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // generator state and configuration
  cwlcg_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upd       (gen_upd),
    .view      (view)
  );

  // selected generator, its product and the combined byte
  always_comb begin
    case (sel)
      GEN_A: begin
        seed_cur = view.gen_a;
        mod_cur  = view.modulus_a;
        sel_next = GEN_B;
      end
      GEN_B: begin
        seed_cur = view.gen_b;
        mod_cur  = view.modulus_b;
        sel_next = GEN_C;
      end
      GEN_C: begin
        seed_cur = view.gen_c;
        mod_cur  = view.modulus_c;
        sel_next = GEN_A;
      end
      default: begin
        seed_cur = view.gen_a;
        mod_cur  = view.modulus_a;
        sel_next = GEN_A;
      end
    endcase
    prod     = 24'(gen_mult(sel)) * 24'(seed_cur);
    rnd_byte = view.gen_a[7:0] ^ view.gen_b[7:0] ^ view.gen_c[7:0];
    last_sel = (sel == GEN_C);
    take     = (value < limit) || (tries == TRY_W'(RETRY_LIMIT - 1));
    out_free = !m_tvalid || m_tready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tdata == 32'd0) ? S_OUT : S_SETUP;
        end
      end
      S_SETUP: state_next = S_LIMW;
      S_LIMW: begin
        if (div_rsp.done) begin
          state_next = S_GEN;
        end
      end
      S_GEN: begin
        if (mod_cur != 16'd0) begin
          state_next = S_GENW;
        end else if (last_sel) begin
          state_next = S_BYTE;
        end
      end
      S_GENW: begin
        if (div_rsp.done) begin
          state_next = last_sel ? S_BYTE : S_GEN;
        end
      end
      S_BYTE:  state_next = (idx == nb_m1) ? S_CHECK : S_GEN;
      S_CHECK: state_next = take ? S_MOD : S_GEN;
      S_MOD:   state_next = S_MODW;
      S_MODW: begin
        if (div_rsp.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = span_ceiling(nb_m1);
    div_req.divisor  = span;
    gen_upd.wr       = 1'b0;
    gen_upd.sel      = sel;
    gen_upd.value    = prod[15:0];
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_SETUP: div_req.start = 1'b1;
      S_GEN: begin
        div_req.dividend = {8'd0, prod};
        div_req.divisor  = {16'd0, mod_cur};
        if (mod_cur != 16'd0) begin
          div_req.start = 1'b1;
        end else begin
          gen_upd.wr = 1'b1;
        end
      end
      S_GENW: begin
        gen_upd.wr    = div_rsp.done;
        gen_upd.value = div_rsp.rem[15:0];
      end
      S_MOD: begin
        div_req.start    = 1'b1;
        div_req.dividend = value;
      end
      default: ;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        span  <= s_tdata;
        nb_m1 <= byte_count_m1(s_tdata);
        res   <= '0;
        tries <= '0;
        idx   <= '0;
        sel   <= GEN_A;
        value <= '0;
      end
      S_LIMW: begin
        if (div_rsp.done) begin
          limit <= span_ceiling(nb_m1) - div_rsp.rem;
        end
      end
      S_GEN: begin
        if (mod_cur == 16'd0) begin
          sel <= sel_next;
        end
      end
      S_GENW: begin
        if (div_rsp.done) begin
          sel <= sel_next;
        end
      end
      S_BYTE: begin
        value[{idx, 3'b000} +: 8] <= rnd_byte;
        idx <= idx + 2'd1;
      end
      S_CHECK: begin
        if (!take) begin
          tries <= tries + TRY_W'(1);
          value <= '0;
          idx   <= '0;
        end
      end
      S_MODW: begin
        if (div_rsp.done) begin
          res <= div_rsp.rem;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= res;
    end
  end

endmodule

@@ hw/rtl/cwlcg_chk.sv @@
// Port-level checks for the combined LCG range generator, bound to the top.
// Depends on the port list of combined_lcg_range_random only.
module cwlcg_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // reset leaves the block ready with no result beat
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("block not idle after reset");

  // one request at a time: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready held after an accepted request");

  // a zero span accepted with no result beat pending answers zero from the output register
  a_zero_span: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata == 32'd0 && !m_tvalid)
      |-> ##2 (m_tvalid && m_tdata == 32'd0))
    else $error("zero span did not give a zero draw");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind combined_lcg_range_random cwlcg_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
